// ===== sv/irb_pkg.sv =====
// shared types and constants of the bilinear image rotator
`default_nettype none

package irb_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd3;

    // item kinds
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam int CFG_W   = 16;  // widest register
    localparam int TRIG_W  = 16;  // q1.14 cosine and sine
    localparam int SIZE_W  = 10;  // rows / cols registers
    localparam int POS_W   = 9;   // row / col fields
    localparam int PIX_W   = 8;
    localparam int DIFF_W  = 11;  // position minus centre
    localparam int PROD_W  = DIFF_W + TRIG_W;
    localparam int XP_W    = 28;  // q.14 source coordinate
    localparam int FRAC_W  = 14;
    localparam int COORD_W = XP_W - FRAC_W;
    localparam int WGT_W   = 8;
    localparam int OUT_W   = 16;

    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [PIX_W-1:0]  pix;
    } item_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_a;
        logic signed [TRIG_W-1:0] sin_a;
        logic [SIZE_W-1:0]        rows;
        logic [SIZE_W-1:0]        cols;
        logic signed [DIFF_W-1:0] cr;
        logic signed [DIFF_W-1:0] cc;
    } geom_t;

    typedef struct packed {
        item_t                  item;
        logic signed [XP_W-1:0] xp;
        logic signed [XP_W-1:0] yp;
    } pos_t;

    typedef struct packed {
        logic                   kind;
        logic [3:0][PIX_W-1:0]  q;       // bank outputs, index {row parity, col parity}
        logic                   px;
        logic                   py;
        logic [3:0]             in_img;  // index {dx, dy}
        logic [WGT_W-1:0]       ax;
        logic [WGT_W-1:0]       ay;
    } tap_t;

endpackage

`default_nettype wire

// ===== sv/irb_coord.sv =====
// inverse rotation of the requested position, three register stages
`default_nettype none

module irb_coord (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire irb_pkg::item_t in_item,
    input  wire irb_pkg::geom_t geom,
    output logic                out_valid,
    input  wire logic           out_ready,
    output irb_pkg::pos_t       out_pos
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    irb_pkg::item_t item1_reg, item2_reg;
    logic signed [irb_pkg::DIFF_W-1:0] di_reg, dj_reg;
    logic signed [irb_pkg::PROD_W-1:0] p_dc_reg, p_ds_reg, p_is_reg, p_jc_reg;
    irb_pkg::pos_t pos_reg;

    logic signed [irb_pkg::DIFF_W-1:0] di_next, dj_next;
    logic signed [irb_pkg::PROD_W-1:0] p_dc_next, p_ds_next, p_is_next, p_jc_next;
    logic signed [irb_pkg::XP_W-1:0]   xp_next, yp_next;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        di_next   = $signed({2'b00, in_item.row}) - geom.cr;
        dj_next   = $signed({2'b00, in_item.col}) - geom.cc;
        p_dc_next = di_reg * geom.cos_a;
        p_ds_next = dj_reg * geom.sin_a;
        p_is_next = di_reg * geom.sin_a;
        p_jc_next = dj_reg * geom.cos_a;
        xp_next   = irb_pkg::XP_W'(p_dc_reg) + irb_pkg::XP_W'(p_ds_reg)
                  + (irb_pkg::XP_W'(geom.cr) <<< irb_pkg::FRAC_W);
        yp_next   = irb_pkg::XP_W'(p_jc_reg) - irb_pkg::XP_W'(p_is_reg)
                  + (irb_pkg::XP_W'(geom.cc) <<< irb_pkg::FRAC_W);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            item1_reg <= in_item;
            di_reg    <= di_next;
            dj_reg    <= dj_next;
        end
        if (adv2) begin
            item2_reg <= item1_reg;
            p_dc_reg  <= p_dc_next;
            p_ds_reg  <= p_ds_next;
            p_is_reg  <= p_is_next;
            p_jc_reg  <= p_jc_next;
        end
        if (adv3) begin
            pos_reg.item <= item2_reg;
            pos_reg.xp   <= xp_next;
            pos_reg.yp   <= yp_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_pos   = pos_reg;

    // a held item is never dropped while the next stage is stalled
    a_hold1: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !adv2) |=> v1_reg) else $error("stage 1 item lost");
    a_hold2: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !adv3) |=> v2_reg) else $error("stage 2 item lost");
    a_hold3: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !out_ready) |=> (v3_reg && $stable(pos_reg)))
        else $error("stage 3 item changed while stalled");

endmodule

`default_nettype wire

// ===== sv/irb_fetch.sv =====
// four parity banks of the source image, neighbour fetch and pixel writes
`default_nettype none

module irb_fetch #(
    parameter int MAX_SIDE = 512
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire irb_pkg::pos_t  in_pos,
    input  wire irb_pkg::geom_t geom,
    output logic                out_valid,
    input  wire logic           out_ready,
    output irb_pkg::tap_t       out_tap
);

    localparam int HALF_W = $clog2((MAX_SIDE + 1) / 2);
    localparam int ADDR_W = 2 * HALF_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CW     = irb_pkg::COORD_W;

    logic v4_reg;
    logic adv4;
    irb_pkg::tap_t meta_reg;
    logic [3:0][irb_pkg::PIX_W-1:0] q_reg;

    logic signed [CW-1:0] x0, y0, x1, y1, xh, yh, rows_s, cols_s;
    logic [CW-1:0] xe, ye;
    logic [3:0] in_img;
    logic [3:0][ADDR_W-1:0] rd_addr;
    logic wr_en;
    logic [1:0] wr_bank;
    logic [ADDR_W-1:0] wr_addr;

    assign adv4     = !v4_reg || out_ready;
    assign in_ready = adv4;

    always_comb begin
        x0     = $signed(in_pos.xp[irb_pkg::XP_W-1:irb_pkg::FRAC_W]);
        y0     = $signed(in_pos.yp[irb_pkg::XP_W-1:irb_pkg::FRAC_W]);
        x1     = x0 + CW'(1);
        y1     = y0 + CW'(1);
        rows_s = $signed(CW'(geom.rows));
        cols_s = $signed(CW'(geom.cols));
        in_img[0] = !x0[CW-1] && (x0 < rows_s) && !y0[CW-1] && (y0 < cols_s);
        in_img[1] = !x0[CW-1] && (x0 < rows_s) && !y1[CW-1] && (y1 < cols_s);
        in_img[2] = !x1[CW-1] && (x1 < rows_s) && !y0[CW-1] && (y0 < cols_s);
        in_img[3] = !x1[CW-1] && (x1 < rows_s) && !y1[CW-1] && (y1 < cols_s);
        // odd row of the pair is x>>1 either way, even row steps up when x is odd
        xh = x0 >>> 1;
        yh = y0 >>> 1;
        xe = CW'(xh) + CW'(x0[0]);
        ye = CW'(yh) + CW'(y0[0]);
        for (int b = 0; b < 4; b++) begin
            rd_addr[b] = {(b[1] ? xh[HALF_W-1:0] : xe[HALF_W-1:0]),
                          (b[0] ? yh[HALF_W-1:0] : ye[HALF_W-1:0])};
        end
        wr_en   = adv4 && in_valid && (in_pos.item.kind == irb_pkg::KIND_WRITE)
                && (32'(in_pos.item.row) < MAX_SIDE) && (32'(in_pos.item.col) < MAX_SIDE);
        wr_bank = {in_pos.item.row[0], in_pos.item.col[0]};
        wr_addr = {HALF_W'(in_pos.item.row >> 1), HALF_W'(in_pos.item.col >> 1)};
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BID = 2'(b);
        logic [irb_pkg::PIX_W-1:0] mem [DEPTH];

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_bank == BID)) begin
                mem[wr_addr] <= in_pos.item.pix;
            end
            if (adv4) begin
                q_reg[b] <= mem[rd_addr[b]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv4) begin
            v4_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            meta_reg.kind   <= in_pos.item.kind;
            meta_reg.q      <= '0;
            meta_reg.px     <= x0[0];
            meta_reg.py     <= y0[0];
            meta_reg.in_img <= in_img;
            meta_reg.ax     <= in_pos.xp[irb_pkg::FRAC_W-1:irb_pkg::FRAC_W-irb_pkg::WGT_W];
            meta_reg.ay     <= in_pos.yp[irb_pkg::FRAC_W-1:irb_pkg::FRAC_W-irb_pkg::WGT_W];
        end
    end

    always_comb begin
        out_tap   = meta_reg;
        out_tap.q = q_reg;
    end
    assign out_valid = v4_reg;

    // opposite corners inside the image put the whole square inside
    a_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && meta_reg.in_img[0] && meta_reg.in_img[3])
        |-> (meta_reg.in_img[1] && meta_reg.in_img[2]))
        else $error("inconsistent neighbour bounds");
    a_hold4: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !out_ready) |=> (v4_reg && $stable(q_reg)))
        else $error("fetched pixels changed while stalled");
    a_nowr: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (in_valid && in_ready)) else $error("write without accepted item");

endmodule

`default_nettype wire

// ===== sv/irb_blend.sv =====
// bilinear weighting of the four neighbours, three register stages
`default_nettype none

module irb_blend (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire irb_pkg::tap_t in_tap,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [irb_pkg::OUT_W-1:0] out_value
);

    localparam int W_W = 2 * irb_pkg::WGT_W + 1;
    localparam int P_W = W_W + irb_pkg::PIX_W;

    logic v5_reg, v6_reg, v7_reg;
    logic adv5, adv6, adv7;

    logic [3:0][irb_pkg::PIX_W-1:0] f_reg;
    logic [3:0][W_W-1:0]            w_reg;
    logic [3:0][P_W-1:0]            p_reg;
    logic [irb_pkg::OUT_W-1:0]      out_reg;

    logic [3:0][irb_pkg::PIX_W-1:0] f_next;
    logic [3:0][W_W-1:0]            w_next;
    logic [3:0][P_W-1:0]            p_next;
    logic [1:0][irb_pkg::WGT_W:0]   wx, wy;
    logic [1:0]                     bsel;
    logic [P_W+1:0]                 sum;
    logic [W_W+1:0]                 wsum;

    assign adv7     = !v7_reg || out_ready;
    assign adv6     = !v6_reg || adv7;
    assign adv5     = !v5_reg || adv6;
    assign in_ready = adv5;

    always_comb begin
        wx[0] = 9'd256 - {1'b0, in_tap.ax};
        wx[1] = {1'b0, in_tap.ax};
        wy[0] = 9'd256 - {1'b0, in_tap.ay};
        wy[1] = {1'b0, in_tap.ay};
        for (int k = 0; k < 4; k++) begin
            bsel      = {in_tap.px ^ k[1], in_tap.py ^ k[0]};
            f_next[k] = in_tap.in_img[k] ? in_tap.q[bsel] : '0;
            w_next[k] = W_W'(wx[k[1]] * wy[k[0]]);
            p_next[k] = P_W'(w_reg[k] * f_reg[k]);
        end
        sum  = (P_W+2)'(p_reg[0]) + (P_W+2)'(p_reg[1])
             + (P_W+2)'(p_reg[2]) + (P_W+2)'(p_reg[3]);
        wsum = (W_W+2)'(w_reg[0]) + (W_W+2)'(w_reg[1])
             + (W_W+2)'(w_reg[2]) + (W_W+2)'(w_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            // write items end here
            if (adv5) v5_reg <= in_valid && (in_tap.kind == irb_pkg::KIND_REQUEST);
            if (adv6) v6_reg <= v5_reg;
            if (adv7) v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv5) begin
            f_reg <= f_next;
            w_reg <= w_next;
        end
        if (adv6) p_reg   <= p_next;
        if (adv7) out_reg <= sum[irb_pkg::OUT_W+7:8];
    end

    assign out_valid = v7_reg;
    assign out_value = out_reg;

    a_wsum: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg |-> (wsum == (W_W+2)'(65536))) else $error("weights do not sum to one");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v6_reg |-> (sum[P_W+1:24] == '0)) else $error("blend sum overflow");
    a_hold7: assert property (@(posedge aclk) disable iff (!aresetn)
        (v7_reg && !out_ready) |=> (v7_reg && $stable(out_reg)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

// ===== sv/image_rotate_bilinear.sv =====
// top level of the bilinear image rotator
//
// usage
//   cfg_wr_en / cfg_addr / cfg_wdata write cos, sin (signed q1.14), rows and cols;
//   write them only while the block is idle
//   s_ channel: kind 0 stores pixel_in at (row, col), kind 1 asks for the
//   rotated pixel at (row, col); one item per cycle may be accepted while s_ready is high
//   m_ channel: one rotated_value (unsigned q8.8) per request, in order;
//   pixel writes give no result
// timing
//   seven register stages: three for the inverse rotation (difference,
//   multiply, sum), one for the banked source read, three for the blend
//   (weights, weighted pixels, sum); one item per cycle while m_ready does not stall
//   the four neighbours come from four row/column parity banks, each read once
//   a cycle, so no item waits for a memory port
// reset and stall
//   reset empties the pipeline and restores the register defaults; the image
//   store is not cleared and must be written before it is read
//   a stall on m_ready backs up stage by stage; empty stages still fill, so
//   s_ready drops only when every stage holds an item
`default_nettype none

module image_rotate_bilinear #(
    parameter int MAX_SIDE = 512
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [irb_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [irb_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_kind,
    input  wire logic [irb_pkg::POS_W-1:0]      s_row,
    input  wire logic [irb_pkg::POS_W-1:0]      s_col,
    input  wire logic [irb_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [irb_pkg::OUT_W-1:0]           m_rotated_value
);

    // configuration registers
    logic [irb_pkg::TRIG_W-1:0] cos_reg, sin_reg;
    logic [irb_pkg::SIZE_W-1:0] rows_reg, cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg  <= 16'd16384;
            sin_reg  <= '0;
            rows_reg <= 10'd512;
            cols_reg <= 10'd512;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                irb_pkg::CFG_COS:  cos_reg  <= cfg_wdata;
                irb_pkg::CFG_SIN:  sin_reg  <= cfg_wdata;
                irb_pkg::CFG_ROWS: rows_reg <= cfg_wdata[irb_pkg::SIZE_W-1:0];
                irb_pkg::CFG_COLS: cols_reg <= cfg_wdata[irb_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes clipped to the store, centre at n/2-1 for even n and n/2 for odd n
    logic [irb_pkg::SIZE_W-1:0] rows_eff, cols_eff;
    irb_pkg::geom_t geom;

    always_comb begin
        rows_eff   = (32'(rows_reg) > MAX_SIDE) ? irb_pkg::SIZE_W'(MAX_SIDE) : rows_reg;
        cols_eff   = (32'(cols_reg) > MAX_SIDE) ? irb_pkg::SIZE_W'(MAX_SIDE) : cols_reg;
        geom.cos_a = $signed(cos_reg);
        geom.sin_a = $signed(sin_reg);
        geom.rows  = rows_eff;
        geom.cols  = cols_eff;
        geom.cr    = $signed({2'b00, rows_eff[irb_pkg::SIZE_W-1:1]})
                   - (rows_eff[0] ? 11'sd0 : 11'sd1);
        geom.cc    = $signed({2'b00, cols_eff[irb_pkg::SIZE_W-1:1]})
                   - (cols_eff[0] ? 11'sd0 : 11'sd1);
    end

    irb_pkg::item_t in_item;
    irb_pkg::pos_t  pos;
    irb_pkg::tap_t  tap;
    logic pos_valid, pos_ready, tap_valid, tap_ready;

    assign in_item.kind = s_kind;
    assign in_item.row  = s_row;
    assign in_item.col  = s_col;
    assign in_item.pix  = s_pixel_in;

    irb_coord u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .geom      (geom),
        .out_valid (pos_valid),
        .out_ready (pos_ready),
        .out_pos   (pos)
    );

    irb_fetch #(
        .MAX_SIDE (MAX_SIDE)
    ) u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pos_valid),
        .in_ready  (pos_ready),
        .in_pos    (pos),
        .geom      (geom),
        .out_valid (tap_valid),
        .out_ready (tap_ready),
        .out_tap   (tap)
    );

    irb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tap_valid),
        .in_ready  (tap_ready),
        .in_tap    (tap),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_value (m_rotated_value)
    );

    // input back-pressure only ever comes from a stalled result
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready)) else $error("input stalled without cause");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result valid after reset");
    a_geom: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(rows_eff) <= MAX_SIDE) && (32'(cols_eff) <= MAX_SIDE))
        else $error("image size exceeds store");

endmodule

`default_nettype wire
